[rtl/core/fbl_pkg.sv]
// fbl_pkg: shared types, constants and arithmetic helpers for the five-bar
// linkage forward kinematics pipeline; no dependencies
`timescale 1ns / 1ps

package fbl_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int GUARD_BITS    = 4;
    localparam int WORK_BITS     = FRACTION_BITS + GUARD_BITS;
    localparam int CORDIC_STEPS  = 18;

    localparam int ANGLE_W    = 20;
    localparam int LENGTH_W   = 18;
    localparam int DATA_W     = 48;
    localparam int LEN_WORK_W = LENGTH_W + GUARD_BITS;
    localparam int SQ_OUT_W   = LEN_WORK_W + 1;
    localparam int SQ_IN_W    = 2 * SQ_OUT_W;
    localparam int SQ_REM_W   = SQ_OUT_W + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = ANGLE_W;

    typedef logic signed [DATA_W-1:0]  wrk_t;
    typedef logic signed [ANGLE_W-1:0] fld_t;

    localparam int          Q32_SHIFT = 32 - WORK_BITS;
    localparam logic [63:0] Q32_HALF  = 64'd1 << (Q32_SHIFT - 1);
    localparam logic [63:0] PI_Q32      = 64'd13493037704;
    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [31:0] GAIN_Q32    = 32'd2608131496;

    localparam wrk_t PI_W      = wrk_t'((PI_Q32 + Q32_HALF) >> Q32_SHIFT);
    localparam wrk_t HALF_PI_W = wrk_t'((HALF_PI_Q32 + Q32_HALF) >> Q32_SHIFT);
    localparam wrk_t TWO_PI_W  = PI_W + PI_W;

    localparam wrk_t ROUND_HALF_W = wrk_t'(1) <<< (GUARD_BITS - 1);
    localparam wrk_t OUT_MAX_W    = (wrk_t'(1) <<< (ANGLE_W - 1)) - wrk_t'(1);
    localparam wrk_t OUT_MIN_W    = -(wrk_t'(1) <<< (ANGLE_W - 1));

    localparam int          ATAN_HEAD_N = 12;
    localparam logic [31:0] ATAN_HEAD [ATAN_HEAD_N] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152
    };

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_ARM    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_ARM    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BASE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_HOME    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_HOME   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSURE_BIAS = 3'd6;

    localparam logic [LENGTH_W-1:0]        RST_UPPER_ARM    = 18'd27277;
    localparam logic [LENGTH_W-1:0]        RST_LOWER_ARM    = 18'd42598;
    localparam logic [LENGTH_W-1:0]        RST_HALF_BASE    = 18'd14090;
    localparam logic signed [LENGTH_W-1:0] RST_BASE_HEIGHT  = 18'sd3814;
    localparam fld_t                       RST_LEFT_HOME    = 20'sd22093;
    localparam fld_t                       RST_RIGHT_HOME   = -20'sd22093;
    localparam fld_t                       RST_CLOSURE_BIAS = 20'sd0;

    typedef struct packed {
        fld_t left_elbow_angle;
        fld_t right_elbow_angle;
    } angle_t;

    typedef struct packed {
        fld_t left_arm_angle;
        fld_t right_arm_angle;
        fld_t closure_angle;
        fld_t tool_y;
        fld_t tool_z;
        logic degenerate;
    } pose_t;

    // values that ride along with a transaction through the pipeline
    typedef struct packed {
        wrk_t tl;
        wrk_t tr;
        wrk_t yl;
        wrk_t zl;
        wrk_t yr;
        wrk_t zr;
        wrk_t yee;
        wrk_t zee;
        wrk_t phi;
        logic degen;
    } ctx_t;

    function automatic wrk_t atan_step(input int i);
        logic [63:0] v;
        if (i < ATAN_HEAD_N)
        begin
            v = 64'(ATAN_HEAD[i[3:0]]);
        end
        else
        begin
            v = 64'd1 << (32 - i);
        end
        return wrk_t'((v + Q32_HALF) >> Q32_SHIFT);
    endfunction

    // second half of the gain multiply: combine partial products and round
    function automatic wrk_t gain_sum(input logic [47:0] hi, input logic [47:0] lo);
        logic [48:0] t;
        t = 49'(hi) + 49'(lo >> 16) + 49'h8000;
        return wrk_t'(t[48:16]);
    endfunction

    function automatic fld_t sat_out(input wrk_t v);
        wrk_t r;
        r = (v + ROUND_HALF_W) >>> GUARD_BITS;
        if (r > OUT_MAX_W)
        begin
            r = OUT_MAX_W;
        end
        else if (r < OUT_MIN_W)
        begin
            r = OUT_MIN_W;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

[rtl/core/five_bar_linkage_forward_kinematics_unit.sv]
// five_bar_linkage_forward_kinematics_unit: top level of the five-bar forward
// kinematics pipeline; depends on fbl_pkg, fbl_rotate, fbl_vector, fbl_sqrt
`timescale 1ns / 1ps

// Fully pipelined: one pose transaction is accepted every cycle unless the
// output register is stalled, and each result passes through the chain of elbow
// rotation, tip-distance vectoring, 23-stage square root, offset rotation and
// arm-angle vectoring (18 steps per CORDIC unit). The whole pipeline holds while
// the output register is stalled. Configuration registers are read live by the
// stages that use them, so write them only while no transaction is in flight.
module five_bar_linkage_forward_kinematics_unit
    import fbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   angle_valid,
    output logic                   angle_stall,
    input  angle_t                 angle_data,
    output logic                   pose_valid,
    input  logic                   pose_stall,
    output pose_t                  pose_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [LENGTH_W-1:0]        upper_reg, lower_reg, half_reg;
    logic signed [LENGTH_W-1:0] base_reg;
    fld_t                       lho_reg, rho_reg, cb_reg;

    logic en;
    wrk_t l1_w, l2_w, l0_w, bz_w, tl_w, tr_w;
    ctx_t ctx_l0, ctx_r0;

    logic rl_valid, rr_valid;
    wrk_t cl, sl, cr, sr;
    ctx_t rl_ctx, rr_ctx;

    logic b1_valid_reg, b2_valid_reg;
    ctx_t b1_ctx_reg, b2_ctx_reg;
    wrk_t dy_reg, dz_reg;

    logic vp_valid, dzero;
    wrk_t phi, dmag;
    ctx_t vp_ctx;

    logic                  c1_valid_reg, c2_valid_reg, c1_degen;
    logic [SQ_OUT_W-1:0]   c1_sum_reg;
    logic [LEN_WORK_W-1:0] c1_dif_reg;
    logic [SQ_IN_W-1:0]    c2_rad_reg;
    ctx_t                  c1_ctx_reg, c2_ctx_reg;
    wrk_t                  half_d, sum_w, dif_w;

    logic                sq_valid;
    logic [SQ_OUT_W-1:0] root;
    ctx_t                sq_ctx;

    logic rh_valid;
    wrk_t hc, hs;
    ctx_t rh_ctx;

    logic d1_valid_reg, d2_valid_reg;
    ctx_t d1_ctx_reg, d2_ctx_reg;
    wrk_t lx_reg, ly_reg, rx_reg, ry_reg;

    logic lv_valid, rv_valid, lv_zero, rv_zero;
    wrk_t lw, rw, lv_mag, rv_mag;
    ctx_t lv_ctx, rv_ctx;

    logic e1_valid_reg, e2_valid_reg;
    wrk_t la_reg, ra_reg, k_reg, la2_reg, ra2_reg, cls_reg;
    ctx_t e1_ctx_reg, e2_ctx_reg;

    logic  pose_valid_reg;
    pose_t pose_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= RST_UPPER_ARM;
            lower_reg <= RST_LOWER_ARM;
            half_reg  <= RST_HALF_BASE;
            base_reg  <= RST_BASE_HEIGHT;
            lho_reg   <= RST_LEFT_HOME;
            rho_reg   <= RST_RIGHT_HOME;
            cb_reg    <= RST_CLOSURE_BIAS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UPPER_ARM:    upper_reg <= cfg_data[LENGTH_W-1:0];
                REG_LOWER_ARM:    lower_reg <= cfg_data[LENGTH_W-1:0];
                REG_HALF_BASE:    half_reg  <= cfg_data[LENGTH_W-1:0];
                REG_BASE_HEIGHT:  base_reg  <= cfg_data[LENGTH_W-1:0];
                REG_LEFT_HOME:    lho_reg   <= cfg_data;
                REG_RIGHT_HOME:   rho_reg   <= cfg_data;
                REG_CLOSURE_BIAS: cb_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign l1_w = wrk_t'(upper_reg) <<< GUARD_BITS;
    assign l2_w = wrk_t'(lower_reg) <<< GUARD_BITS;
    assign l0_w = wrk_t'(half_reg) <<< GUARD_BITS;
    assign bz_w = wrk_t'(base_reg) <<< GUARD_BITS;

    // global pipeline advance
    assign en          = !pose_valid_reg || !pose_stall;
    assign angle_stall = !en;

    assign tl_w = wrk_t'(angle_data.left_elbow_angle) <<< GUARD_BITS;
    assign tr_w = wrk_t'(angle_data.right_elbow_angle) <<< GUARD_BITS;

    always_comb
    begin
        ctx_l0    = '0;
        ctx_l0.tl = tl_w;
        ctx_r0    = '0;
        ctx_r0.tr = tr_w;
    end

    // elbow tips
    fbl_rotate u_rot_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (angle_valid),
        .in_mag   (l1_w),
        .in_ang   (tl_w),
        .in_ctx   (ctx_l0),
        .out_valid(rl_valid),
        .out_cos  (cl),
        .out_sin  (sl),
        .out_ctx  (rl_ctx)
    );

    fbl_rotate u_rot_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (angle_valid),
        .in_mag   (l1_w),
        .in_ang   (tr_w),
        .in_ctx   (ctx_r0),
        .out_valid(rr_valid),
        .out_cos  (cr),
        .out_sin  (sr),
        .out_ctx  (rr_ctx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= rl_valid && rr_valid;
            b1_ctx_reg    <= rl_ctx;
            b1_ctx_reg.tr <= rr_ctx.tr;
            b1_ctx_reg.yl <= cl - l0_w;
            b1_ctx_reg.zl <= bz_w + sl;
            b1_ctx_reg.yr <= l0_w + cr;
            b1_ctx_reg.zr <= bz_w + sr;
        end
    end

    // tip difference and midpoint
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b2_valid_reg   <= b1_valid_reg;
            dy_reg         <= b1_ctx_reg.yl - b1_ctx_reg.yr;
            dz_reg         <= b1_ctx_reg.zl - b1_ctx_reg.zr;
            b2_ctx_reg     <= b1_ctx_reg;
            b2_ctx_reg.yee <= (b1_ctx_reg.yl + b1_ctx_reg.yr) >>> 1;
            b2_ctx_reg.zee <= (b1_ctx_reg.zl + b1_ctx_reg.zr) >>> 1;
        end
    end

    fbl_vector u_vec_tips (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b2_valid_reg),
        .in_x     (dy_reg),
        .in_y     (dz_reg),
        .in_ctx   (b2_ctx_reg),
        .out_valid(vp_valid),
        .out_ang  (phi),
        .out_mag  (dmag),
        .out_zero (dzero),
        .out_ctx  (vp_ctx)
    );

    // circle intersection height, squared
    assign c1_degen = dzero || (dmag > (l2_w <<< 1));
    assign half_d   = dmag >>> 1;
    assign sum_w    = l2_w + half_d;
    assign dif_w    = l2_w - half_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg     <= vp_valid;
            c1_sum_reg       <= c1_degen ? '0 : sum_w[SQ_OUT_W-1:0];
            c1_dif_reg       <= c1_degen ? '0 : dif_w[LEN_WORK_W-1:0];
            c1_ctx_reg       <= vp_ctx;
            c1_ctx_reg.phi   <= phi;
            c1_ctx_reg.degen <= c1_degen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c2_valid_reg <= c1_valid_reg;
            c2_rad_reg   <= SQ_IN_W'(c1_sum_reg) * SQ_IN_W'(c1_dif_reg);
            c2_ctx_reg   <= c1_ctx_reg;
        end
    end

    fbl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c2_valid_reg),
        .in_rad   (c2_rad_reg),
        .in_ctx   (c2_ctx_reg),
        .out_valid(sq_valid),
        .out_root (root),
        .out_ctx  (sq_ctx)
    );

    fbl_rotate u_rot_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .in_mag   (wrk_t'(root)),
        .in_ang   (sq_ctx.phi),
        .in_ctx   (sq_ctx),
        .out_valid(rh_valid),
        .out_cos  (hc),
        .out_sin  (hs),
        .out_ctx  (rh_ctx)
    );

    // end-effector point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_valid_reg <= rh_valid;
            d1_ctx_reg   <= rh_ctx;
            if (!rh_ctx.degen)
            begin
                d1_ctx_reg.yee <= rh_ctx.yee + hs;
                d1_ctx_reg.zee <= rh_ctx.zee - hc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d2_valid_reg <= d1_valid_reg;
            d2_ctx_reg   <= d1_ctx_reg;
            lx_reg       <= d1_ctx_reg.zee - d1_ctx_reg.zl;
            ly_reg       <= d1_ctx_reg.yee - d1_ctx_reg.yl;
            rx_reg       <= d1_ctx_reg.zee - d1_ctx_reg.zr;
            ry_reg       <= d1_ctx_reg.yee - d1_ctx_reg.yr;
        end
    end

    // passive arm world angles
    fbl_vector u_vec_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d2_valid_reg),
        .in_x     (lx_reg),
        .in_y     (ly_reg),
        .in_ctx   (d2_ctx_reg),
        .out_valid(lv_valid),
        .out_ang  (lw),
        .out_mag  (lv_mag),
        .out_zero (lv_zero),
        .out_ctx  (lv_ctx)
    );

    fbl_vector u_vec_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d2_valid_reg),
        .in_x     (rx_reg),
        .in_y     (ry_reg),
        .in_ctx   (d2_ctx_reg),
        .out_valid(rv_valid),
        .out_ang  (rw),
        .out_mag  (rv_mag),
        .out_zero (rv_zero),
        .out_ctx  (rv_ctx)
    );

    // zero vectors already give a zero angle; the magnitude is only checked alongside the zero flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg <= lv_valid && rv_valid;
            la_reg       <= (lv_zero && (lv_mag == '0)) ? -(wrk_t'(lho_reg) <<< GUARD_BITS)
                                                         : lw - (wrk_t'(lho_reg) <<< GUARD_BITS);
            ra_reg       <= (rv_zero && (rv_mag == '0)) ? -(wrk_t'(rho_reg) <<< GUARD_BITS)
                                                         : rw - (wrk_t'(rho_reg) <<< GUARD_BITS);
            k_reg        <= (wrk_t'(cb_reg) <<< GUARD_BITS) + rv_ctx.tr - lv_ctx.tl;
            e1_ctx_reg   <= lv_ctx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e2_valid_reg <= e1_valid_reg;
            la2_reg      <= la_reg;
            ra2_reg      <= ra_reg;
            cls_reg      <= k_reg + ra_reg - la_reg;
            e2_ctx_reg   <= e1_ctx_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pose_valid_reg           <= e2_valid_reg;
            pose_reg.left_arm_angle  <= sat_out(la2_reg);
            pose_reg.right_arm_angle <= sat_out(ra2_reg);
            pose_reg.closure_angle   <= sat_out(cls_reg);
            pose_reg.tool_y          <= sat_out(e2_ctx_reg.yee);
            pose_reg.tool_z          <= sat_out(e2_ctx_reg.zee);
            pose_reg.degenerate      <= e2_ctx_reg.degen;
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose_data  = pose_reg;

endmodule

[rtl/core/fbl_rotate.sv]
// fbl_rotate: pipelined CORDIC rotation of a magnitude by an angle, with
// angle wrapping and gain pre-scaling; depends on fbl_pkg
`timescale 1ns / 1ps

module fbl_rotate
    import fbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  wrk_t in_mag,
    input  wrk_t in_ang,
    input  ctx_t in_ctx,
    output logic out_valid,
    output wrk_t out_cos,
    output wrk_t out_sin,
    output ctx_t out_ctx
);

    function automatic wrk_t wrap(input wrk_t a);
        if (a > PI_W)
        begin
            return a - TWO_PI_W;
        end
        else if (a < -PI_W)
        begin
            return a + TWO_PI_W;
        end
        return a;
    endfunction

    logic        v1_reg, v2_reg;
    wrk_t        ang1_reg, ang2_reg, mag2_reg;
    logic [47:0] hi1_reg, lo1_reg;
    ctx_t        ctx1_reg, ctx2_reg;
    logic [31:0] mag_bits;

    logic v_reg    [CORDIC_STEPS+1];
    wrk_t x_reg    [CORDIC_STEPS+1];
    wrk_t y_reg    [CORDIC_STEPS+1];
    wrk_t z_reg    [CORDIC_STEPS+1];
    logic flip_reg [CORDIC_STEPS+1];
    ctx_t ctx_reg  [CORDIC_STEPS+1];

    logic out_valid_reg;
    wrk_t cos_reg, sin_reg;
    ctx_t out_ctx_reg;

    assign mag_bits = in_mag[31:0];

    // wrap once, start gain multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            ang1_reg <= wrap(in_ang);
            hi1_reg  <= 48'(mag_bits[31:16]) * 48'(GAIN_Q32);
            lo1_reg  <= 48'(mag_bits[15:0]) * 48'(GAIN_Q32);
            ctx1_reg <= in_ctx;
        end
    end

    // wrap twice, finish gain multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg   <= v1_reg;
            ang2_reg <= wrap(ang1_reg);
            mag2_reg <= gain_sum(hi1_reg, lo1_reg);
            ctx2_reg <= ctx1_reg;
        end
    end

    // fold into the right half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0]   <= v2_reg;
            x_reg[0]   <= mag2_reg;
            y_reg[0]   <= '0;
            ctx_reg[0] <= ctx2_reg;
            if (ang2_reg > HALF_PI_W)
            begin
                z_reg[0]    <= ang2_reg - PI_W;
                flip_reg[0] <= 1'b1;
            end
            else if (ang2_reg < -HALF_PI_W)
            begin
                z_reg[0]    <= ang2_reg + PI_W;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]    <= ang2_reg;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            localparam wrk_t ATAN_I = atan_step(i);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1]    <= v_reg[i];
                    flip_reg[i+1] <= flip_reg[i];
                    ctx_reg[i+1]  <= ctx_reg[i];
                    if (z_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - ATAN_I;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + ATAN_I;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[CORDIC_STEPS];
            out_ctx_reg   <= ctx_reg[CORDIC_STEPS];
            if (flip_reg[CORDIC_STEPS])
            begin
                cos_reg <= -x_reg[CORDIC_STEPS];
                sin_reg <= -y_reg[CORDIC_STEPS];
            end
            else
            begin
                cos_reg <= x_reg[CORDIC_STEPS];
                sin_reg <= y_reg[CORDIC_STEPS];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

[rtl/core/fbl_vector.sv]
// fbl_vector: pipelined CORDIC vectoring, angle and gain-corrected magnitude
// of an (x, y) pair; depends on fbl_pkg
`timescale 1ns / 1ps

module fbl_vector
    import fbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  wrk_t in_x,
    input  wrk_t in_y,
    input  ctx_t in_ctx,
    output logic out_valid,
    output wrk_t out_ang,
    output wrk_t out_mag,
    output logic out_zero,
    output ctx_t out_ctx
);

    logic v_reg    [CORDIC_STEPS+1];
    wrk_t x_reg    [CORDIC_STEPS+1];
    wrk_t y_reg    [CORDIC_STEPS+1];
    wrk_t z_reg    [CORDIC_STEPS+1];
    logic zero_reg [CORDIC_STEPS+1];
    ctx_t ctx_reg  [CORDIC_STEPS+1];

    logic        vp_reg, zp_reg;
    wrk_t        angp_reg;
    logic [47:0] hip_reg, lop_reg;
    ctx_t        ctxp_reg;
    logic [31:0] x_bits;

    logic out_valid_reg, out_zero_reg;
    wrk_t ang_reg, mag_reg;
    ctx_t out_ctx_reg;

    // left half plane is mirrored through the origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0]    <= in_valid;
            ctx_reg[0]  <= in_ctx;
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x < 0)
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= (in_y >= 0) ? PI_W : -PI_W;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
        end
    end

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            localparam wrk_t ATAN_I = atan_step(i);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1]    <= v_reg[i];
                    zero_reg[i+1] <= zero_reg[i];
                    ctx_reg[i+1]  <= ctx_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + ATAN_I;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - ATAN_I;
                    end
                end
            end
        end
    endgenerate

    assign x_bits = (x_reg[CORDIC_STEPS] < 0) ? 32'd0 : x_reg[CORDIC_STEPS][31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg   <= v_reg[CORDIC_STEPS];
            zp_reg   <= zero_reg[CORDIC_STEPS];
            angp_reg <= zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];
            hip_reg  <= 48'(x_bits[31:16]) * 48'(GAIN_Q32);
            lop_reg  <= 48'(x_bits[15:0]) * 48'(GAIN_Q32);
            ctxp_reg <= ctx_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vp_reg;
            out_zero_reg  <= zp_reg;
            ang_reg       <= angp_reg;
            mag_reg       <= gain_sum(hip_reg, lop_reg);
            out_ctx_reg   <= ctxp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ang   = ang_reg;
    assign out_mag   = mag_reg;
    assign out_zero  = out_zero_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

[rtl/core/fbl_sqrt.sv]
// fbl_sqrt: pipelined digit-by-digit integer square root, one result bit per
// stage; depends on fbl_pkg
`timescale 1ns / 1ps

module fbl_sqrt
    import fbl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_IN_W-1:0]  in_rad,
    input  ctx_t                in_ctx,
    output logic                out_valid,
    output logic [SQ_OUT_W-1:0] out_root,
    output ctx_t                out_ctx
);

    logic                v_reg    [SQ_OUT_W+1];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_OUT_W+1];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W+1];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W+1];
    ctx_t                ctx_reg  [SQ_OUT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0]    <= in_valid;
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            ctx_reg[0]  <= in_ctx;
        end
    end

    generate
        for (genvar k = 0; k < SQ_OUT_W; k++)
        begin : g_digit
            logic [SQ_REM_W-1:0] rem_sh, trial;
            assign rem_sh = {rem_reg[k][SQ_REM_W-3:0], rad_reg[k][SQ_IN_W-1 -: 2]};
            assign trial  = {root_reg[k], 2'b01};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k+1]   <= v_reg[k];
                    rad_reg[k+1] <= rad_reg[k] << 2;
                    ctx_reg[k+1] <= ctx_reg[k];
                    if (rem_sh >= trial)
                    begin
                        rem_reg[k+1]  <= rem_sh - trial;
                        root_reg[k+1] <= {root_reg[k][SQ_OUT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1]  <= rem_sh;
                        root_reg[k+1] <= {root_reg[k][SQ_OUT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SQ_OUT_W];
    assign out_root  = root_reg[SQ_OUT_W];
    assign out_ctx   = ctx_reg[SQ_OUT_W];

endmodule
